// ===== hw/rtl/gtph_pkg.sv =====
// ----------------------------------------------------------------------------
// GTPv1 header parser package
// Request types, verdict codes and header layout constants shared by the
// parser modules.
// ----------------------------------------------------------------------------
package gtph_pkg;

  // Header layout
  localparam int unsigned DEFAULT_MAX_PACKET_LEN = 65535;
  localparam int unsigned CNT_W          = 16;
  localparam int unsigned MIN_LEN_W      = 5;
  localparam logic [4:0]  MIN_LEN_RESET  = 5'd8;
  localparam logic [15:0] HDR_BASE_LEN   = 16'd8;   // mandatory header
  localparam logic [15:0] HDR_OPT_LEN    = 16'd12;  // with seq/N-PDU/next-type
  localparam logic [15:0] POS_FLAGS      = 16'd0;
  localparam logic [15:0] POS_MSG_TYPE   = 16'd1;
  localparam logic [15:0] POS_TEID_FIRST = 16'd4;
  localparam logic [15:0] POS_TEID_LAST  = 16'd7;
  localparam logic [15:0] POS_NEXT_TYPE  = 16'd11;
  localparam logic [2:0]  GTP_VERSION    = 3'd1;

  // Verdict codes
  typedef enum logic [2:0] {
    STATUS_ACCEPTED  = 3'd0,
    STATUS_TOO_SHORT = 3'd1,
    STATUS_BAD_VER   = 3'd2,
    STATUS_NO_OPT    = 3'd3,
    STATUS_BAD_EXT   = 3'd4
  } status_e;

  // One packet byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  // One verdict
  typedef struct packed {
    status_e     status;
    logic [31:0] tunnel_endpoint_id;
    logic [7:0]  message_type;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
  } out_req_t;

  // Header tracking state after taking the current byte
  typedef struct packed {
    logic [15:0] byte_count;
    logic [7:0]  flag_byte;
    logic [7:0]  type_byte;
    logic [31:0] teid;
    logic [7:0]  next_ext_type;
    logic [15:0] header_end;
    logic        chain_error;
  } hdr_state_t;

endpackage

// ===== hw/rtl/gtph_hdr_track.sv =====
// ----------------------------------------------------------------------------
// GTPv1 header tracker
// Captures the fixed header fields byte by byte and follows the chain of
// extension headers. Shows the state including the current byte.
// ----------------------------------------------------------------------------
module gtph_hdr_track
  import gtph_pkg::*;
#(
  parameter int unsigned MAX_PACKET_LEN = DEFAULT_MAX_PACKET_LEN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_en_i,
  input  in_req_t    byte_i,
  output hdr_state_t state_o
);

  localparam logic [CNT_W:0] MaxLenExt = (CNT_W + 1)'(MAX_PACKET_LEN);

  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  flag_q, flag_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] teid_q, teid_d;
  logic [7:0]  next_q, next_d;
  logic [15:0] eend_q, eend_d;
  logic [15:0] hend_q, hend_d;
  logic        cerr_q, cerr_d;

  logic        take;
  logic [7:0]  b;
  logic [16:0] ext_sum;

  assign b       = byte_i.data_byte;
  assign take    = ({1'b0, cnt_q} < MaxLenExt);
  assign ext_sum = {1'b0, hend_q} + {7'b0, b, 2'b00};

  // Next state for the current byte
  always_comb begin
    cnt_d  = cnt_q;
    flag_d = flag_q;
    type_d = type_q;
    teid_d = teid_q;
    next_d = next_q;
    eend_d = eend_q;
    hend_d = hend_q;
    cerr_d = cerr_q;
    if (take) begin
      cnt_d = cnt_q + 16'd1;
      // fixed header fields
      if (cnt_q == POS_FLAGS) begin
        flag_d = b;
        if (b[2:0] != 3'b000) begin
          hend_d = HDR_OPT_LEN;
        end
      end else if (cnt_q == POS_MSG_TYPE) begin
        type_d = b;
      end else if (cnt_q >= POS_TEID_FIRST && cnt_q <= POS_TEID_LAST) begin
        teid_d = {teid_q[23:0], b};
      end
      // extension chain, only with E set and no error so far
      if (flag_d[2] && !cerr_q) begin
        if (cnt_q == POS_NEXT_TYPE) begin
          next_d = b;
        end else if (next_q != 8'd0 && cnt_q == hend_q) begin
          // length byte of an extension, in 4-byte units
          if (b == 8'd0) begin
            cerr_d = 1'b1;
          end else if (ext_sum > MaxLenExt) begin
            cerr_d = 1'b1;
          end else begin
            hend_d = ext_sum[15:0];
            eend_d = ext_sum[15:0];
            next_d = 8'd0;
          end
        end else if (eend_q != 16'd0 && ({1'b0, cnt_q} + 17'd1) == {1'b0, eend_q}) begin
          // last byte of an extension carries the next type
          next_d = b;
          eend_d = 16'd0;
        end
      end
    end
  end

  // State registers, cleared after the final byte of a packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      flag_q <= '0;
      type_q <= '0;
      teid_q <= '0;
      next_q <= '0;
      eend_q <= '0;
      hend_q <= HDR_BASE_LEN;
      cerr_q <= 1'b0;
    end else if (byte_en_i) begin
      if (byte_i.last_byte) begin
        cnt_q  <= '0;
        flag_q <= '0;
        type_q <= '0;
        teid_q <= '0;
        next_q <= '0;
        eend_q <= '0;
        hend_q <= HDR_BASE_LEN;
        cerr_q <= 1'b0;
      end else begin
        cnt_q  <= cnt_d;
        flag_q <= flag_d;
        type_q <= type_d;
        teid_q <= teid_d;
        next_q <= next_d;
        eend_q <= eend_d;
        hend_q <= hend_d;
        cerr_q <= cerr_d;
      end
    end
  end

  assign state_o.byte_count    = cnt_d;
  assign state_o.flag_byte     = flag_d;
  assign state_o.type_byte     = type_d;
  assign state_o.teid          = teid_d;
  assign state_o.next_ext_type = next_d;
  assign state_o.header_end    = hend_d;
  assign state_o.chain_error   = cerr_d;

endmodule

// ===== hw/rtl/gtph_verdict.sv =====
// ----------------------------------------------------------------------------
// GTPv1 verdict stage
// Turns the header state at the final byte into a verdict and holds it in
// the result register until the downstream side takes it.
// ----------------------------------------------------------------------------
module gtph_verdict
  import gtph_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  hdr_state_t     state_i,
  input  logic [4:0]     min_len_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output out_req_t       out_req_o
);

  logic     valid_q;
  out_req_t res_q, res_d;
  logic     ext;
  logic     hend_over;
  logic     ext_bad;

  assign ext       = state_i.flag_byte[2];
  assign hend_over = state_i.header_end > state_i.byte_count;
  assign ext_bad   = ext && (state_i.chain_error || state_i.next_ext_type != 8'd0 || hend_over);

  // Check order: length, version, flags, extension chain, header length
  always_comb begin
    res_d.tunnel_endpoint_id = state_i.teid;
    res_d.message_type       = state_i.type_byte;
    res_d.payload_offset     = 16'd0;
    res_d.payload_length     = 16'd0;
    if (state_i.byte_count < {11'd0, min_len_i}) begin
      res_d.status = STATUS_TOO_SHORT;
    end else if (state_i.flag_byte[7:5] != GTP_VERSION) begin
      res_d.status = STATUS_BAD_VER;
    end else if (state_i.flag_byte[2:0] == 3'b000) begin
      res_d.status = STATUS_NO_OPT;
    end else if (ext_bad) begin
      res_d.status = STATUS_BAD_EXT;
    end else if (hend_over) begin
      res_d.status = STATUS_TOO_SHORT;
    end else begin
      res_d.status         = STATUS_ACCEPTED;
      res_d.payload_offset = state_i.header_end;
      res_d.payload_length = state_i.byte_count - state_i.header_end;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fire_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_d;
    end
  end

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_req_o   = res_q;

endmodule

// ===== hw/rtl/gtpv1_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// GTPv1 header parser unit
// Parses a GTPv1 packet streamed one byte per request and gives one verdict
// with TEID, message type, payload offset and payload length per packet.
// ----------------------------------------------------------------------------
// A packet enters one byte per request, the final byte marked by last_byte,
// and the unit takes one byte every cycle unless a final byte waits as told
// below. Each byte is held in the input register and, as it moves on,
// updates the header state (field capture and extension chain); the final
// byte writes the verdict into the result register at that same edge, which
// drives out_valid_o. Only a final byte waits in the input register, and
// only while an earlier verdict is still held by out_stall_i; other bytes
// keep flowing. min_header_len is to be written through cfg_we_i/cfg_wdata_i
// only while no packet is in flight; the unit does not enforce this.
module gtpv1_header_parser_unit
  import gtph_pkg::*;
#(
  parameter int unsigned MAX_PACKET_LEN = DEFAULT_MAX_PACKET_LEN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [MIN_LEN_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_req_t              in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_req_t             out_req_o
);

  logic [MIN_LEN_W-1:0] min_len_q;
  logic                 s1_valid_q;
  in_req_t              s1_req_q;
  logic                 s1_adv;
  logic                 in_take;
  logic                 byte_en;
  logic                 out_free;
  hdr_state_t           hdr_state;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RESET;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  // Input register; a final byte moves on only when the result slot frees
  assign s1_adv     = !s1_req_q.last_byte || out_free;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign byte_en    = s1_valid_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q <= in_req_i;
    end
  end

  // Header state
  gtph_hdr_track #(
    .MAX_PACKET_LEN(MAX_PACKET_LEN)
  ) u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_en_i(byte_en),
    .byte_i   (s1_req_q),
    .state_o  (hdr_state)
  );

  // Verdict and result register
  gtph_verdict u_verdict (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (byte_en && s1_req_q.last_byte),
    .state_i    (hdr_state),
    .min_len_i  (min_len_q),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

endmodule

// ===== tb/tb_gtpv1_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// GTPv1 header parser unit testbench
// Streams GTPv1 packets into the parser one byte per request, predicts each
// verdict from its own header tracker and checks every field of every result.
// Both sides idle and stall at random in turns, under several length limits.
// ----------------------------------------------------------------------------
module tb_gtpv1_header_parser_unit
  import gtph_pkg::*;
();

  localparam int unsigned PKT_LIMIT   = DEFAULT_MAX_PACKET_LEN;
  localparam int unsigned STUCK_LIMIT = 2000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [4:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  in_req_t    in_req_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_req_t   out_req_o;

  gtpv1_header_parser_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle and stall chances, percent per cycle
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  int unsigned mismatch_count;
  int unsigned verdicts_checked;
  int unsigned packets_sent;
  int unsigned bytes_sent;
  int unsigned stuck_cycles;

  logic [7:0] pkt_q[$];
  out_req_t   verdict_q[$];

  // Header tracker state
  int unsigned min_len_m;
  int unsigned seen_bytes;
  logic [7:0]  flags_m;
  logic [7:0]  mtype_m;
  logic [31:0] teid_m;
  logic [7:0]  next_type_m;
  int unsigned ext_end_m;    // 0: no next-type byte awaited
  int unsigned hdr_end_m;
  bit          chain_bad_m;

  function automatic void clear_tracker();
    seen_bytes  = 0;
    flags_m     = '0;
    mtype_m     = '0;
    teid_m      = '0;
    next_type_m = '0;
    ext_end_m   = 0;
    hdr_end_m   = 32'(HDR_BASE_LEN);
    chain_bad_m = 1'b0;
  endfunction

  // Field capture and extension chain walk for the byte at pos
  function automatic void track_header_byte(int unsigned pos, logic [7:0] b);
    int unsigned ext_end;
    if (pos == POS_FLAGS) begin
      flags_m = b;
      if (b[2:0] != 3'b000) hdr_end_m = 32'(HDR_OPT_LEN);
    end else if (pos == POS_MSG_TYPE) begin
      mtype_m = b;
    end else if (pos >= POS_TEID_FIRST && pos <= POS_TEID_LAST) begin
      teid_m = {teid_m[23:0], b};
    end
    if (!flags_m[2] || chain_bad_m) return;
    if (pos == POS_NEXT_TYPE) begin
      next_type_m = b;
    end else if (next_type_m != 0 && pos == hdr_end_m) begin
      ext_end = hdr_end_m + 4 * int'(b);
      if (b == 8'h00 || ext_end > PKT_LIMIT) begin
        chain_bad_m = 1'b1;
      end else begin
        hdr_end_m   = ext_end;
        ext_end_m   = ext_end;
        next_type_m = '0;
      end
    end else if (ext_end_m != 0 && pos + 1 == ext_end_m) begin
      next_type_m = b;
      ext_end_m   = 0;
    end
  endfunction

  // Update the tracker with one accepted byte; queue a verdict on the last one
  function automatic void predict_verdict(logic [7:0] b, bit last);
    out_req_t    v;
    int unsigned len;
    if (seen_bytes < PKT_LIMIT) begin
      track_header_byte(seen_bytes, b);
      seen_bytes++;
    end
    if (!last) return;
    len = seen_bytes;
    v.tunnel_endpoint_id = teid_m;
    v.message_type       = mtype_m;
    v.payload_offset     = '0;
    v.payload_length     = '0;
    if (len < min_len_m) begin
      v.status = STATUS_TOO_SHORT;
    end else if (flags_m[7:5] != GTP_VERSION) begin
      v.status = STATUS_BAD_VER;
    end else if (flags_m[2:0] == 3'b000) begin
      v.status = STATUS_NO_OPT;
    end else if (flags_m[2] && (chain_bad_m || next_type_m != 0 || hdr_end_m > len)) begin
      v.status = STATUS_BAD_EXT;
    end else if (hdr_end_m > len) begin
      v.status = STATUS_TOO_SHORT;
    end else begin
      v.status         = STATUS_ACCEPTED;
      v.payload_offset = hdr_end_m[15:0];
      v.payload_length = 16'(len - hdr_end_m);
    end
    verdict_q.push_back(v);
    clear_tracker();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    mismatch_count++;
    $display("MISMATCH at verdict %0d: %s got 0x%0h expected 0x%0h",
             verdicts_checked, what, got, exp);
  endtask

  task automatic check_verdict(out_req_t got);
    out_req_t exp;
    if (verdict_q.size() == 0) begin
      report_mismatch("verdict with no packet pending", 32'(got.status), '0);
      return;
    end
    exp = verdict_q.pop_front();
    verdicts_checked++;
    if (got.status !== exp.status)
      report_mismatch("status", 32'(got.status), 32'(exp.status));
    if (got.tunnel_endpoint_id !== exp.tunnel_endpoint_id)
      report_mismatch("teid", got.tunnel_endpoint_id, exp.tunnel_endpoint_id);
    if (got.message_type !== exp.message_type)
      report_mismatch("message_type", 32'(got.message_type), 32'(exp.message_type));
    if (got.payload_offset !== exp.payload_offset)
      report_mismatch("payload_offset", 32'(got.payload_offset), 32'(exp.payload_offset));
    if (got.payload_length !== exp.payload_length)
      report_mismatch("payload_length", 32'(got.payload_length), 32'(exp.payload_length));
  endtask

  // Result side: check accepted verdicts, then pick the next stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_verdict(out_req_o);
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stuck_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", stuck_cycles);
        $display("Mismatches found");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // One byte request; valid stays up for the next byte unless an idle follows
  task automatic send_byte(logic [7:0] b, bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{data_byte: b, last_byte: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_verdict(b, last);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1);
    packets_sent++;
  endtask

  // Drain all verdicts and let the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_min_header_len(int unsigned value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 5'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    min_len_m   = value & 31;
  endtask

  // Packet builders
  function automatic void start_header(logic [7:0] flags, bit with_opt,
                                       logic [7:0] next_type);
    pkt_q.delete();
    pkt_q.push_back(flags);
    repeat (7) pkt_q.push_back(8'($urandom));
    if (with_opt) begin
      repeat (3) pkt_q.push_back(8'($urandom));
      pkt_q.push_back(next_type);
    end
  endfunction

  function automatic void set_ids(logic [7:0] mtype, logic [31:0] teid);
    pkt_q[POS_MSG_TYPE] = mtype;
    for (int i = 0; i < 4; i++) pkt_q[POS_TEID_FIRST + i] = teid[31 - 8 * i -: 8];
  endfunction

  function automatic void add_extension(int units, logic [7:0] next_type);
    pkt_q.push_back(8'(units));
    repeat (4 * units - 2) pkt_q.push_back(8'($urandom));
    pkt_q.push_back(next_type);
  endfunction

  function automatic void add_payload(int n);
    repeat (n) pkt_q.push_back(8'($urandom));
  endfunction

  function automatic void fill_bytes(int n, logic [7:0] value);
    pkt_q.delete();
    repeat (n) pkt_q.push_back(value);
  endfunction

  // Mostly well-formed headers with random content, the rest broken or noise
  function automatic void build_random_packet();
    int unsigned kind;
    logic [2:0]  fl;
    int          n_ext;
    int unsigned cut;
    int unsigned idx;
    kind  = $urandom_range(0, 99);
    fl    = 3'($urandom_range(0, 7));
    n_ext = fl[2] ? $urandom_range(0, 3) : 0;
    start_header({GTP_VERSION, 2'($urandom_range(0, 3)), fl}, fl != 3'b000,
                 (n_ext > 0) ? 8'($urandom_range(1, 255)) :
                 (fl[2] ? 8'h00 : 8'($urandom)));
    for (int i = 0; i < n_ext; i++)
      add_extension($urandom_range(1, 3), (i == n_ext - 1) ? 8'h00 : 8'($urandom_range(1, 255)));
    add_payload($urandom_range(0, 12));
    if (kind < 62) begin
      // keep as built
    end else if (kind < 72) begin
      pkt_q[POS_FLAGS][7:5] = 3'($urandom_range(2, 8));
    end else if (kind < 82) begin
      cut = $urandom_range(1, pkt_q.size());
      while (pkt_q.size() > cut) void'(pkt_q.pop_back());
    end else if (kind < 88) begin
      if (n_ext > 0) pkt_q[HDR_OPT_LEN] = 8'h00;
    end else if (kind < 94) begin
      pkt_q.delete();
      repeat ($urandom_range(1, 24)) pkt_q.push_back(8'($urandom));
    end else begin
      idx = $urandom_range(0, pkt_q.size() - 1);
      pkt_q[idx] = pkt_q[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
  endfunction

  // Mandatory header, version check and optional field rules
  task automatic test_header_fields();
    fill_bytes(8, 8'h00);
    send_packet();
    fill_bytes(1, 8'hFF);
    send_packet();
    start_header({GTP_VERSION, 2'b11, 3'b000}, 1'b0, 8'h00);
    set_ids(8'hFF, 32'hFFFF_FFFF);
    send_packet();
    start_header({GTP_VERSION, 2'b10, 3'b010}, 1'b1, 8'hAA);
    set_ids(8'h00, 32'h0000_0000);
    send_packet();
    // PN set but the optional bytes cut short
    start_header({GTP_VERSION, 2'b10, 3'b001}, 1'b1, 8'h00);
    void'(pkt_q.pop_back());
    void'(pkt_q.pop_back());
    send_packet();
    fill_bytes(8, 8'hFF);
    send_packet();
    start_header({GTP_VERSION, 2'b10, 3'b011}, 1'b1, 8'h55);
    set_ids(8'hFF, 32'h1234_5678);
    add_payload(5);
    send_packet();
  endtask

  // Extension header chain: good chains and each way a chain breaks
  task automatic test_extension_chain();
    start_header({GTP_VERSION, 2'b10, 3'b100}, 1'b1, 8'h00);
    add_payload(3);
    send_packet();
    start_header({GTP_VERSION, 2'b10, 3'b100}, 1'b1, 8'h85);
    add_extension(1, 8'h00);
    add_payload(4);
    send_packet();
    start_header({GTP_VERSION, 2'b10, 3'b111}, 1'b1, 8'hFF);
    add_extension(20, 8'hC0);
    add_extension(1, 8'h00);
    send_packet();
    // zero extension length
    start_header({GTP_VERSION, 2'b10, 3'b100}, 1'b1, 8'h85);
    pkt_q.push_back(8'h00);
    add_payload(6);
    send_packet();
    // chain still open at the end of the packet
    start_header({GTP_VERSION, 2'b10, 3'b100}, 1'b1, 8'h85);
    add_extension(1, 8'h40);
    send_packet();
    // packet ends inside an extension
    start_header({GTP_VERSION, 2'b10, 3'b100}, 1'b1, 8'h85);
    add_extension(2, 8'h00);
    repeat (3) void'(pkt_q.pop_back());
    send_packet();
    start_header({GTP_VERSION, 2'b10, 3'b100}, 1'b1, 8'h01);
    send_packet();
    // version fault wins over a good chain
    start_header({3'd2, 2'b10, 3'b100}, 1'b1, 8'h85);
    add_extension(1, 8'h00);
    send_packet();
  endtask

  // Length limit extremes
  task automatic test_min_header_len();
    set_min_header_len(31);
    start_header({GTP_VERSION, 2'b10, 3'b010}, 1'b1, 8'h00);
    add_payload(18);
    send_packet();
    start_header({GTP_VERSION, 2'b10, 3'b010}, 1'b1, 8'h00);
    add_payload(19);
    send_packet();
    set_min_header_len(0);
    fill_bytes(1, {GTP_VERSION, 5'b00000});
    send_packet();
    fill_bytes(1, {GTP_VERSION, 5'b00001});
    send_packet();
    fill_bytes(1, {GTP_VERSION, 5'b00100});
    send_packet();
    set_min_header_len(16);
    start_header({3'd7, 2'b10, 3'b001}, 1'b1, 8'h00);
    add_payload(3);
    send_packet();
  endtask

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                     int unsigned min_len, int unsigned budget);
    int unsigned start_bytes;
    set_min_header_len(min_len);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_bytes    = bytes_sent;
    while (bytes_sent - start_bytes < budget) begin
      build_random_packet();
      send_packet();
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    in_req_i       <= '0;
    packets_sent     = 0;
    bytes_sent       = 0;
    send_idle_pct    = 17;
    recv_stall_pct   = 57;
    min_len_m        = MIN_LEN_RESET;
    clear_tracker();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_min_header_len(MIN_LEN_RESET);
    test_header_fields();
    test_extension_chain();
    test_min_header_len();
    test_random_traffic(17, 57, 16, 115);
    test_random_traffic(17, 57, $urandom_range(9, 15), 115);
    test_random_traffic(57, 17, 31, 115);
    test_random_traffic(57, 17, 0, 115);
    test_random_traffic(0, 0, MIN_LEN_RESET, 115);
    test_random_traffic(0, 0, $urandom_range(0, 31), 115);

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d packets (%0d bytes): header fields, extension chains, length limits,",
             packets_sent, bytes_sent);
    $display("  random traffic under three idle patterns; %0d verdicts checked",
             verdicts_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
